FILE: sv/lsfw_pkg.sv
package lsfw_pkg;

   // register indexes on the configuration port (byte address 4*index)
   localparam logic [2:0] REG_WIDE_WORDS   = 3'd0;
   localparam logic [2:0] REG_CS_LEAD      = 3'd1;
   localparam logic [2:0] REG_CS_SETUP     = 3'd2;
   localparam logic [2:0] REG_BIT_SETUP    = 3'd3;
   localparam logic [2:0] REG_BIT_CLOCK    = 3'd4;
   localparam logic [2:0] REG_CS_HOLD      = 3'd5;

   // reset values of the timing registers
   localparam logic [15:0] RST_CS_LEAD   = 16'd41;
   localparam logic [15:0] RST_CS_SETUP  = 16'd31;
   localparam logic [15:0] RST_BIT_SETUP = 16'd26;
   localparam logic [15:0] RST_BIT_CLOCK = 16'd51;
   localparam logic [15:0] RST_CS_HOLD   = 16'd21;

   // frame headers
   localparam logic [2:0] HDR_CMD  = 3'b100;
   localparam logic [2:0] HDR_DATA = 3'b101;

   // input operation codes
   localparam logic OP_CMD  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   // bit counts of the fixed frame parts
   localparam int HDR_BITS = 3;
   localparam int CMD_BITS = 12;   // header, command byte, trailing zero
   localparam int NARROW_BITS = 8;
   localparam int WIDE_BITS = 16;

endpackage

FILE: sv/lsfw_if.sv
interface lsfw_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [15:0] value;
   logic [6:0]  start_address;
   logic        first;
   logic        last;

   modport source (output valid, op, value, start_address, first, last, input ready);
   modport sink   (input valid, op, value, start_address, first, last, output ready);
endinterface

interface lsfw_rsp_if;
   logic        valid;
   logic        ready;
   logic        cs_active;
   logic        wr_active;
   logic        data_level;
   logic [15:0] hold_cycles;
   logic        last_res;

   modport source (output valid, cs_active, wr_active, data_level, hold_cycles, last_res,
                   input ready);
   modport sink   (input valid, cs_active, wr_active, data_level, hold_cycles, last_res,
                   output ready);
endinterface

FILE: sv/led_driver_serial_frame_writer.sv
// channel   direction  payload
// req       in         op, value[15:0], start_address[6:0], first, last
// rsp       out        cs_active, wr_active, data_level, hold_cycles[15:0], last_res
// csr       apb        six registers at byte address 4*index, 32-bit data
//
// one item is taken, then its segments leave at one per cycle while rsp is ready:
// 2*n bit segments (n = 8..3+ADDR_BITS+16 from the serial shift register) plus up
// to five framing segments; the next item is taken only once the phase is idle again.
// a stall on rsp holds the current segment; reset closes any open frame and
// restores the register reset values

module led_driver_serial_frame_writer #(
   parameter int ADDR_BITS = 7
) (
   input  logic               clock,
   input  logic               reset,
   lsfw_req_if.sink           req,
   lsfw_rsp_if.source         rsp,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int SH_W  = lsfw_pkg::HDR_BITS + ADDR_BITS + lsfw_pkg::WIDE_BITS;
   localparam int CNT_W = $clog2(SH_W + 1);

   // segment phases
   localparam logic [2:0] P_IDLE      = 3'd0;
   localparam logic [2:0] P_CLOSE_PRE = 3'd1;
   localparam logic [2:0] P_LEAD      = 3'd2;
   localparam logic [2:0] P_ASSERT    = 3'd3;
   localparam logic [2:0] P_BIT_ON    = 3'd4;
   localparam logic [2:0] P_BIT_OFF   = 3'd5;
   localparam logic [2:0] P_CLOSE     = 3'd6;
   localparam logic [2:0] P_RELEASE   = 3'd7;

   logic        wide_ff;
   logic [15:0] lead_ff, setup_ff, bset_ff, bclk_ff, hold_ff;
   logic [2:0]  phase_ff, phase_in;
   logic        frame_open_ff, frame_open_in;
   logic        do_open_ff, do_open_in;
   logic        post_ff, post_in;
   logic [SH_W-1:0]  sh_ff, sh_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic        req_fire, rsp_fire, csr_write;
   logic        pre_close, do_open, post_close;
   logic [ADDR_BITS+22:0]  addr_ext;
   logic [ADDR_BITS-1:0]   addr_bits;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff  <= 1'b0;
         lead_ff  <= lsfw_pkg::RST_CS_LEAD;
         setup_ff <= lsfw_pkg::RST_CS_SETUP;
         bset_ff  <= lsfw_pkg::RST_BIT_SETUP;
         bclk_ff  <= lsfw_pkg::RST_BIT_CLOCK;
         hold_ff  <= lsfw_pkg::RST_CS_HOLD;
      end else if (csr_write && csr_paddr[1:0] == 2'b00) begin
         case (csr_paddr[4:2])
            lsfw_pkg::REG_WIDE_WORDS: wide_ff  <= csr_pwdata[0];
            lsfw_pkg::REG_CS_LEAD:    lead_ff  <= csr_pwdata[15:0];
            lsfw_pkg::REG_CS_SETUP:   setup_ff <= csr_pwdata[15:0];
            lsfw_pkg::REG_BIT_SETUP:  bset_ff  <= csr_pwdata[15:0];
            lsfw_pkg::REG_BIT_CLOCK:  bclk_ff  <= csr_pwdata[15:0];
            lsfw_pkg::REG_CS_HOLD:    hold_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register read-back
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[1:0] == 2'b00) begin
         case (csr_paddr[4:2])
            lsfw_pkg::REG_WIDE_WORDS: csr_prdata = {31'd0, wide_ff};
            lsfw_pkg::REG_CS_LEAD:    csr_prdata = {16'd0, lead_ff};
            lsfw_pkg::REG_CS_SETUP:   csr_prdata = {16'd0, setup_ff};
            lsfw_pkg::REG_BIT_SETUP:  csr_prdata = {16'd0, bset_ff};
            lsfw_pkg::REG_BIT_CLOCK:  csr_prdata = {16'd0, bclk_ff};
            lsfw_pkg::REG_CS_HOLD:    csr_prdata = {16'd0, hold_ff};
            default:                  csr_prdata = 32'd0;
         endcase
      end
   end

   // handshakes
   assign req.ready = (phase_ff == P_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;

   // item decode
   assign addr_ext   = {{(ADDR_BITS + 16){1'b0}}, req.start_address};
   assign addr_bits  = addr_ext[ADDR_BITS-1:0];
   assign pre_close  = frame_open_ff && (req.op == lsfw_pkg::OP_CMD || req.first);
   assign do_open    = (req.op == lsfw_pkg::OP_CMD) || !frame_open_ff || req.first;
   assign post_close = (req.op == lsfw_pkg::OP_CMD) || req.last;

   // sequencer and bit shifter
   always_comb begin
      phase_in      = phase_ff;
      frame_open_in = frame_open_ff;
      do_open_in    = do_open_ff;
      post_in       = post_ff;
      sh_in         = sh_ff;
      cnt_in        = cnt_ff;
      if (req_fire) begin
         do_open_in    = do_open;
         post_in       = post_close;
         frame_open_in = (req.op == lsfw_pkg::OP_DATA) && !req.last;
         if (pre_close)    phase_in = P_CLOSE_PRE;
         else if (do_open) phase_in = P_LEAD;
         else              phase_in = P_BIT_ON;
         // load the bits left-aligned, count in cnt
         if (req.op == lsfw_pkg::OP_CMD) begin
            sh_in  = {lsfw_pkg::HDR_CMD, req.value[7:0], 1'b0, {(SH_W - 12){1'b0}}};
            cnt_in = CNT_W'(lsfw_pkg::CMD_BITS);
         end else if (do_open && wide_ff) begin
            sh_in  = {lsfw_pkg::HDR_DATA, addr_bits, req.value};
            cnt_in = CNT_W'(SH_W);
         end else if (do_open) begin
            sh_in  = {lsfw_pkg::HDR_DATA, addr_bits, req.value[7:0], 8'd0};
            cnt_in = CNT_W'(SH_W - 8);
         end else if (wide_ff) begin
            sh_in  = {req.value, {(SH_W - 16){1'b0}}};
            cnt_in = CNT_W'(lsfw_pkg::WIDE_BITS);
         end else begin
            sh_in  = {req.value[7:0], {(SH_W - 8){1'b0}}};
            cnt_in = CNT_W'(lsfw_pkg::NARROW_BITS);
         end
      end else if (rsp_fire) begin
         case (phase_ff)
            P_CLOSE_PRE: phase_in = do_open_ff ? P_LEAD : P_BIT_ON;
            P_LEAD:      phase_in = P_ASSERT;
            P_ASSERT:    phase_in = P_BIT_ON;
            P_BIT_ON:    phase_in = P_BIT_OFF;
            P_BIT_OFF: begin
               if (cnt_ff == CNT_W'(1)) begin
                  phase_in = post_ff ? P_CLOSE : P_IDLE;
               end else begin
                  phase_in = P_BIT_ON;
                  sh_in    = {sh_ff[SH_W-2:0], 1'b0};
                  cnt_in   = cnt_ff - CNT_W'(1);
               end
            end
            P_CLOSE:     phase_in = P_RELEASE;
            P_RELEASE:   phase_in = P_IDLE;
            default:     phase_in = P_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= P_IDLE;
         frame_open_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         frame_open_ff <= frame_open_in;
      end
   end

   always_ff @(posedge clock) begin
      do_open_ff <= do_open_in;
      post_ff    <= post_in;
      sh_ff      <= sh_in;
      cnt_ff     <= cnt_in;
   end

   // segment payload from the current phase
   assign rsp.valid = (phase_ff != P_IDLE);

   always_comb begin
      rsp.cs_active   = 1'b0;
      rsp.wr_active   = 1'b0;
      rsp.data_level  = 1'b0;
      rsp.hold_cycles = 16'd0;
      rsp.last_res    = 1'b0;
      case (phase_ff)
         P_CLOSE_PRE, P_CLOSE: begin
            rsp.cs_active   = 1'b1;
            rsp.hold_cycles = hold_ff;
         end
         P_LEAD:   rsp.hold_cycles = lead_ff;
         P_ASSERT: begin
            rsp.cs_active   = 1'b1;
            rsp.hold_cycles = setup_ff;
         end
         P_BIT_ON: begin
            rsp.cs_active   = 1'b1;
            rsp.wr_active   = 1'b1;
            rsp.data_level  = sh_ff[SH_W-1];
            rsp.hold_cycles = bset_ff;
         end
         P_BIT_OFF: begin
            rsp.cs_active   = 1'b1;
            rsp.data_level  = sh_ff[SH_W-1];
            rsp.hold_cycles = bclk_ff;
            rsp.last_res    = (cnt_ff == CNT_W'(1)) && !post_ff;
         end
         P_RELEASE: rsp.last_res = 1'b1;
         default: ;
      endcase
   end

endmodule
